// File: rtl/ubfe_pkg.sv
// ----------------------------------------------------------------------------
// ubfe_pkg
// Shared types and constants of the buffered UART frame engine.
// ----------------------------------------------------------------------------
package ubfe_pkg;

  localparam int unsigned TX_DEPTH_DEF = 64;
  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd5;

  typedef enum logic [2:0] {
    MODE_RX_BYTE  = 3'd0,
    MODE_TX_READY = 3'd1,
    MODE_TICK     = 3'd2,
    MODE_TX_QUEUE = 3'd3,
    MODE_FINISH   = 3'd4,
    MODE_READ_RX  = 3'd5
  } mode_e;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data;
    logic [5:0] index;
  } evt_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_ready;
    logic [6:0] frame_length;
    logic [7:0] read_byte;
    logic       tx_active;
    logic       tx_overrun;
  } res_t;

  typedef struct packed {
    logic       sent;
    logic [7:0] tx_byte;
    logic       active;
    logic       overrun;
  } tx_rsp_t;

  typedef struct packed {
    logic       ready;
    logic [6:0] length;
    logic [7:0] read_byte;
  } rx_rsp_t;

endpackage

// File: rtl/ubfe_stream_if.sv
// ----------------------------------------------------------------------------
// ubfe_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ubfe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/uart_buffered_frame_engine_top.sv
// ----------------------------------------------------------------------------
// uart_buffered_frame_engine_top
// One UART channel's buffering: transmit ring queue and idle-timed rx frame.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  evt_i     in   mode, data, index                              valid/ready
//  res_o     out  tx_valid, tx_byte, frame_ready, frame_length,  valid/ready
//                 read_byte, tx_active, tx_overrun
//  cfg       in   idle_timeout_ticks                             cfg_we_i
//
//  Pointers update and the RAM read issues in the accept cycle; the registered
//  RAM data is loaded into the result register in the response state.
//  One word is in flight at a time; the result register frees the input side
//  as soon as it is loaded. A stalled result holds the engine in its response
//  state. No clearing pass after reset: RAM contents are don't-care until written.
// ----------------------------------------------------------------------------
module uart_buffered_frame_engine_top
  import ubfe_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  ubfe_stream_if.sink   evt_i,
  ubfe_stream_if.source res_o
);

  state_e     state_q, state_d;
  logic [7:0] timeout_q;
  logic       go;
  logic       slot_free;
  logic       load;
  logic       out_valid_q;
  res_t       out_q;
  tx_rsp_t    tx_rsp;
  rx_rsp_t    rx_rsp;

  assign go        = evt_i.valid && evt_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (go) state_d = S_RESP;
      S_RESP: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    evt_i.ready = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      S_IDLE: evt_i.ready = 1'b1;
      S_RESP: load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.tx_valid     <= tx_rsp.sent;
      out_q.tx_byte      <= tx_rsp.tx_byte;
      out_q.frame_ready  <= rx_rsp.ready;
      out_q.frame_length <= rx_rsp.length;
      out_q.read_byte    <= rx_rsp.read_byte;
      out_q.tx_active    <= tx_rsp.active;
      out_q.tx_overrun   <= tx_rsp.overrun;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  ubfe_tx #(
    .TX_DEPTH (TX_DEPTH)
  ) u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .mode_i (evt_i.payload.mode),
    .data_i (evt_i.payload.data),
    .rsp_o  (tx_rsp)
  );

  ubfe_rx #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .mode_i    (evt_i.payload.mode),
    .data_i    (evt_i.payload.data),
    .index_i   (evt_i.payload.index),
    .timeout_i (timeout_q),
    .rsp_o     (rx_rsp)
  );

  // every accepted word is answered in the following state
  a_go_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> state_q == S_RESP)
    else $error("accepted word not followed by response state");

  // a byte handed to the shifter implies the transmitter is busy
  a_sent_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && tx_rsp.sent |-> tx_rsp.active)
    else $error("byte sent while transmitter idle");

  // no byte sent means a zero byte field
  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !tx_rsp.sent |-> tx_rsp.tx_byte == 8'd0)
    else $error("tx byte nonzero without send");

endmodule

// File: rtl/ubfe_ram.sv
// ----------------------------------------------------------------------------
// ubfe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ubfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ubfe_tx.sv
// ----------------------------------------------------------------------------
// ubfe_tx
// Transmit ring queue: pointers, busy flag and the queue RAM.
// ----------------------------------------------------------------------------
module ubfe_tx
  import ubfe_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_i,
  output tx_rsp_t    rsp_o
);

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);

  logic [TX_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [TX_AW-1:0] head_inc, tail_inc;
  logic             busy_q, busy_d;
  logic             sent_q, sent_d;
  logic             fwd_q, fwd_d;
  logic             ovr_q, ovr_d;
  logic [7:0]       fwd_byte_q;
  logic             we, re;
  logic [7:0]       rdata;

  assign head_inc = (head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    busy_d = busy_q;
    sent_d = 1'b0;
    fwd_d  = 1'b0;
    ovr_d  = 1'b0;
    we     = 1'b0;
    re     = 1'b0;
    case (mode_i)
      MODE_TX_READY: begin
        if (tail_q != head_q) begin
          re     = go_i;
          sent_d = 1'b1;
          tail_d = tail_inc;
        end else begin
          busy_d = 1'b0;
        end
      end
      MODE_TX_QUEUE: begin
        we     = go_i;
        head_d = head_inc;
        ovr_d  = (head_inc == tail_q);
        if (!busy_q) begin
          busy_d = 1'b1;
          if (tail_q != head_inc) begin
            sent_d = 1'b1;
            tail_d = tail_inc;
            // popping the slot being written: take the byte straight from the input
            fwd_d  = (tail_q == head_q);
            re     = go_i && (tail_q != head_q);
          end else begin
            busy_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      busy_q <= 1'b0;
      sent_q <= 1'b0;
      fwd_q  <= 1'b0;
      ovr_q  <= 1'b0;
    end else if (go_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      busy_q <= busy_d;
      sent_q <= sent_d;
      fwd_q  <= fwd_d;
      ovr_q  <= ovr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      fwd_byte_q <= data_i;
    end
  end

  ubfe_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (head_q),
    .wdata_i (data_i),
    .re_i    (re),
    .raddr_i (tail_q),
    .rdata_o (rdata)
  );

  assign rsp_o.sent    = sent_q;
  assign rsp_o.tx_byte = !sent_q ? 8'd0 : (fwd_q ? fwd_byte_q : rdata);
  assign rsp_o.active  = busy_q;
  assign rsp_o.overrun = ovr_q;

endmodule

// File: rtl/ubfe_rx.sv
// ----------------------------------------------------------------------------
// ubfe_rx
// Receive frame buffer with idle countdown and the frame RAM.
// ----------------------------------------------------------------------------
module ubfe_rx
  import ubfe_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_i,
  input  logic [5:0] index_i,
  input  logic [7:0] timeout_i,
  output rx_rsp_t    rsp_o
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned RX_LW = $clog2(RX_DEPTH + 1);

  logic [RX_LW-1:0]   len_q, len_d, len_base;
  logic [RX_LW+6:0]   len_ext;
  logic [7:0]         cd_q, cd_d, cd_dec;
  logic               cmpl_q, cmpl_d;
  logic               rd_sel_q, rd_sel_d;
  logic [RX_AW+5:0]   idx_ext;
  logic               idx_ok;
  logic               we, re;
  logic [RX_AW-1:0]   waddr;
  logic [7:0]         rdata;

  // a full buffer restarts the frame at position zero
  assign len_base = (len_q >= RX_LW'(RX_DEPTH)) ? '0 : len_q;
  assign waddr    = len_base[RX_AW-1:0];
  assign idx_ext  = (RX_AW + 6)'(index_i);
  assign idx_ok   = idx_ext < (RX_AW + 6)'(RX_DEPTH);
  assign cd_dec   = (cd_q != 8'd0) ? cd_q - 8'd1 : cd_q;

  always_comb begin
    len_d    = len_q;
    cd_d     = cd_q;
    cmpl_d   = cmpl_q;
    rd_sel_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    case (mode_i)
      MODE_RX_BYTE: begin
        if (!cmpl_q) begin
          we    = go_i;
          len_d = len_base + 1'b1;
          cd_d  = timeout_i;
        end
      end
      MODE_TICK: begin
        if (len_q != '0) begin
          cd_d = cd_dec;
          if (cd_dec == 8'd0) begin
            cmpl_d = 1'b1;
          end
        end
      end
      MODE_FINISH: begin
        len_d  = '0;
        cmpl_d = 1'b0;
      end
      MODE_READ_RX: begin
        re       = go_i && idx_ok;
        rd_sel_d = idx_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      cd_q     <= '0;
      cmpl_q   <= 1'b0;
      rd_sel_q <= 1'b0;
    end else if (go_i) begin
      len_q    <= len_d;
      cd_q     <= cd_d;
      cmpl_q   <= cmpl_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  ubfe_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_i),
    .re_i    (re),
    .raddr_i (idx_ext[RX_AW-1:0]),
    .rdata_o (rdata)
  );

  assign len_ext         = (RX_LW + 7)'(len_q);
  assign rsp_o.ready     = cmpl_q;
  assign rsp_o.length    = len_ext[6:0];
  assign rsp_o.read_byte = rd_sel_q ? rdata : 8'd0;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uart_buffered_frame_engine_top. A mirror of the
// tx ring queue and the idle-timed rx frame predicts every result word. The
// stimulus opens with a short directed run over the corner cases, then goes
// through phases of random frames, tx bursts, queue overruns and frame wraps,
// one idle timeout setting per phase. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import ubfe_pkg::*;

  localparam int TXD = TX_DEPTH_DEF;
  localparam int RXD = RX_DEPTH_DEF;
  localparam int TXP = $clog2(TXD);
  localparam int RXP = $clog2(RXD);
  localparam int ITEM_GOAL  = 1850;
  localparam int PHASE_GOAL = 280;

  // opcodes outside the defined set; the engine must leave its state alone
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0]          timeout;
    logic [TXD-1:0][7:0] txq;
    logic [TXP-1:0]      tx_wr;
    logic [TXP-1:0]      tx_rd;
    logic                tx_busy;
    logic [RXD-1:0][7:0] rxbuf;
    logic [RXD-1:0]      rx_written;
    logic [RXP:0]        rx_len;
    logic [7:0]          rx_count;
    logic                rx_done;
  } engine_mirror_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_data;

  ubfe_stream_if #(.T(evt_t)) evt_if ();
  ubfe_stream_if #(.T(res_t)) res_if ();

  uart_buffered_frame_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  engine_mirror_t plan_mirror;   // tracks the stimulus as it is generated
  engine_mirror_t check_mirror;  // advanced on each accepted word
  evt_t           pending_events[$];
  res_t           expected_results[$];
  res_t           next_expect;
  int             evt_wait;
  int             res_stall;
  int             res_gap;
  int             evt_profile;
  int             res_profile;
  int             error_count;
  int             planned_items;
  bit             long_frame_due;

  function automatic int idle_gap(input int profile);
    case (profile)
      0:       return 0;
      1:       return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 13) : 0;
      default: return $urandom_range(0, 13);
    endcase
  endfunction

  function automatic void tx_pop(inout engine_mirror_t m, inout res_t r);
    if (m.tx_rd != m.tx_wr) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = m.txq[m.tx_rd];
      m.tx_rd    = m.tx_rd + 1'b1;
    end else begin
      m.tx_busy = 1'b0;
    end
  endfunction

  function automatic res_t step_engine(inout engine_mirror_t m, input evt_t e);
    res_t r;
    r = '0;
    case (e.mode)
      MODE_RX_BYTE: begin
        if (!m.rx_done) begin
          if (m.rx_len >= RXD) m.rx_len = '0;
          m.rxbuf[m.rx_len[RXP-1:0]]      = e.data;
          m.rx_written[m.rx_len[RXP-1:0]] = 1'b1;
          m.rx_len   = m.rx_len + 1'b1;
          m.rx_count = m.timeout;
        end
      end
      MODE_TX_READY: tx_pop(m, r);
      MODE_TICK: begin
        if (m.rx_len != 0) begin
          if (m.rx_count != 0) m.rx_count = m.rx_count - 1'b1;
          if (m.rx_count == 0) m.rx_done = 1'b1;
        end
      end
      MODE_TX_QUEUE: begin
        m.txq[m.tx_wr] = e.data;
        m.tx_wr        = m.tx_wr + 1'b1;
        r.tx_overrun   = (m.tx_wr == m.tx_rd);
        if (!m.tx_busy) begin
          m.tx_busy = 1'b1;
          tx_pop(m, r);
        end
      end
      MODE_FINISH: begin
        m.rx_len  = '0;
        m.rx_done = 1'b0;
      end
      MODE_READ_RX: r.read_byte = m.rxbuf[e.index];
      default: ;
    endcase
    r.frame_ready  = m.rx_done;
    r.frame_length = m.rx_len;
    r.tx_active    = m.tx_busy;
    return r;
  endfunction

  // --- stimulus planning ----------------------------------------------------

  task automatic queue_event(input logic [2:0] mode, input logic [7:0] data,
                             input logic [5:0] index);
    evt_t e;
    res_t unused;
    e.mode  = mode;
    e.data  = data;
    e.index = index;
    planned_items++;
    pending_events.push_back(e);
    unused = step_engine(plan_mirror, e);
  endtask

  task automatic queue_simple(input logic [2:0] mode);
    queue_event(mode, 8'($urandom), 6'($urandom));
  endtask

  // reads only entries that hold a received byte; a tick stands in otherwise
  task automatic queue_read();
    int start;
    int pick;
    start = $urandom_range(0, RXD - 1);
    pick  = -1;
    for (int i = 0; i < RXD; i++) begin
      if (pick < 0 && plan_mirror.rx_written[(start + i) % RXD]) pick = (start + i) % RXD;
    end
    if (pick < 0) queue_simple(MODE_TICK);
    else queue_event(MODE_READ_RX, 8'($urandom), 6'(pick));
  endtask

  task automatic queue_tx_noise();
    if ($urandom_range(0, 1) == 0) queue_simple(MODE_TX_QUEUE);
    else queue_simple(MODE_TX_READY);
  endtask

  task automatic plan_frame();
    int bytes;
    int ticks;
    int t;
    t     = plan_mirror.timeout;
    bytes = $urandom_range(1, 12);
    for (int i = 0; i < bytes; i++) begin
      queue_simple(MODE_RX_BYTE);
      if ($urandom_range(0, 5) == 0) queue_tx_noise();
    end
    if (long_frame_due || t <= 16) ticks = t + $urandom_range(0, 2);
    else ticks = $urandom_range(0, 3);
    if (t <= 16 && $urandom_range(0, 3) == 0) ticks = $urandom_range(0, t - 1);
    long_frame_due = 1'b0;
    for (int i = 0; i < ticks; i++) begin
      queue_simple(MODE_TICK);
      if ($urandom_range(0, 4) == 0) queue_tx_noise();
    end
    if (plan_mirror.rx_done && $urandom_range(0, 1) == 0) queue_simple(MODE_RX_BYTE);
    repeat ($urandom_range(0, 3)) queue_read();
    if ($urandom_range(0, 4) != 0) queue_simple(MODE_FINISH);
  endtask

  task automatic plan_tx_burst();
    repeat ($urandom_range(2, 20)) begin
      if ($urandom_range(0, 2) != 0) queue_simple(MODE_TX_QUEUE);
      else queue_simple(MODE_TX_READY);
    end
    repeat ($urandom_range(0, 5)) queue_simple(MODE_TX_READY);
  endtask

  // fills the ring up to or past its depth with the transmitter stalled, then drains
  task automatic plan_overrun();
    repeat ($urandom_range(TXD - 1, TXD + 2)) queue_simple(MODE_TX_QUEUE);
    repeat ($urandom_range(0, TXD + 6)) queue_simple(MODE_TX_READY);
  endtask

  task automatic plan_rx_wrap();
    if (plan_mirror.rx_done) queue_simple(MODE_FINISH);
    repeat ($urandom_range(RXD, RXD + 8)) queue_simple(MODE_RX_BYTE);
    repeat (4) queue_read();
    if ($urandom_range(0, 2) != 0) queue_simple(MODE_FINISH);
  endtask

  task automatic plan_noise();
    logic [2:0] mode;
    repeat ($urandom_range(3, 10)) begin
      mode = 3'($urandom_range(0, 5));
      if (mode == MODE_READ_RX) queue_read();
      else queue_simple(mode);
    end
  endtask

  task automatic plan_directed();
    queue_simple(MODE_TX_READY);                   // empty queue, not busy
    queue_simple(MODE_TICK);                       // empty frame
    queue_simple(MODE_FINISH);
    queue_simple(MODE_SPARE_A);
    queue_simple(MODE_SPARE_B);
    queue_event(MODE_TX_QUEUE, 8'hFF, 6'h00);      // idle: sent in the same word
    queue_event(MODE_TX_QUEUE, 8'h00, 6'h3F);
    queue_event(MODE_TX_QUEUE, 8'hA5, 6'h15);
    repeat (3) queue_simple(MODE_TX_READY);        // last one clears busy
    queue_event(MODE_RX_BYTE, 8'h00, 6'h2A);
    queue_event(MODE_RX_BYTE, 8'hFF, 6'h00);
    queue_event(MODE_RX_BYTE, 8'h5A, 6'h3F);
    queue_event(MODE_READ_RX, 8'h00, 6'd0);
    queue_event(MODE_READ_RX, 8'hFF, 6'd2);
    repeat (TIMEOUT_RST) queue_simple(MODE_TICK);  // completes on the last
    queue_simple(MODE_TICK);                       // countdown already zero
    queue_event(MODE_RX_BYTE, 8'h3C, 6'h0);        // frame complete: dropped
    queue_simple(MODE_FINISH);
    queue_event(MODE_READ_RX, 8'h00, 6'd1);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || evt_if.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_timeout(input logic [7:0] ticks);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    plan_mirror.timeout  = ticks;
    check_mirror.timeout = ticks;
    @(negedge clk_i);
  endtask

  // --- clock, reset, driver and monitor -----------------------------------

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    fork
      forever #4 clk_i = ~clk_i;
      begin
        repeat (8) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_if.valid   <= 1'b0;
      evt_if.payload <= '0;
      evt_wait       <= 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        expected_results.push_back(step_engine(check_mirror, evt_if.payload));
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (evt_wait != 0) begin
          evt_if.valid <= 1'b0;
          evt_wait     <= evt_wait - 1;
        end else if (pending_events.size() != 0) begin
          evt_if.valid   <= 1'b1;
          evt_if.payload <= pending_events.pop_front();
          evt_wait       <= idle_gap(evt_profile);
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall    <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result word %h at %0t", res_if.payload, $realtime);
      end else begin
        next_expect = expected_results.pop_front();
        if (res_if.payload !== next_expect) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch at %0t: tx_valid %b/%b tx_byte %h/%h frame_ready %b/%b ",
                      "frame_length %0d/%0d read_byte %h/%h tx_active %b/%b ",
                      "tx_overrun %b/%b (expected/actual)"}, $realtime,
                     next_expect.tx_valid, res_if.payload.tx_valid,
                     next_expect.tx_byte, res_if.payload.tx_byte,
                     next_expect.frame_ready, res_if.payload.frame_ready,
                     next_expect.frame_length, res_if.payload.frame_length,
                     next_expect.read_byte, res_if.payload.read_byte,
                     next_expect.tx_active, res_if.payload.tx_active,
                     next_expect.tx_overrun, res_if.payload.tx_overrun);
        end
      end
      res_gap       = idle_gap(res_profile);
      res_stall    <= res_gap;
      res_if.ready <= (res_gap == 0);
    end else if (res_stall != 0) begin
      res_stall    <= res_stall - 1;
      res_if.ready <= (res_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // --- test sequence --------------------------------------------------------

  initial begin
    int phase;
    int phase_start;
    int pick;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    plan_mirror         = '0;
    plan_mirror.timeout = TIMEOUT_RST;
    check_mirror        = plan_mirror;
    error_count         = 0;
    planned_items       = 0;
    long_frame_due      = 1'b0;
    evt_profile         = 1;
    res_profile         = 1;
    @(posedge rst_ni);
    @(negedge clk_i);
    plan_directed();
    wait_idle();
    phase = 0;
    while (planned_items < ITEM_GOAL) begin
      case (phase % 5)
        0:       set_timeout(8'd1);
        1:       set_timeout(8'd255);
        3:       set_timeout(8'($urandom_range(13, 254)));
        default: set_timeout(8'($urandom_range(2, 12)));
      endcase
      evt_profile    = $urandom_range(0, 2);
      res_profile    = $urandom_range(0, 2);
      long_frame_due = 1'b1;
      phase_start    = planned_items;
      if (phase == 0) begin
        plan_rx_wrap();
        plan_overrun();
      end
      while (planned_items - phase_start < PHASE_GOAL && planned_items < ITEM_GOAL) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) plan_frame();
        else if (pick <= 5) plan_tx_burst();
        else if (pick == 6) plan_overrun();
        else if (pick == 7) plan_rx_wrap();
        else plan_noise();
      end
      wait_idle();
      phase++;
    end
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ubfe_pkg.sv
rtl/ubfe_stream_if.sv
rtl/ubfe_ram.sv
rtl/ubfe_tx.sv
rtl/ubfe_rx.sv
rtl/uart_buffered_frame_engine_top.sv
bench/tb.sv
